### hdl/framed_record_byte_ring_assert.svh
// Assertion macros for the framed record byte ring.
// Included by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef FRAMED_RECORD_BYTE_RING_ASSERT_SVH
`define FRAMED_RECORD_BYTE_RING_ASSERT_SVH

// same-cycle implication, masked while reset is held
`define FRB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is held
`define FRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/frb_pkg.sv
// Shared types and codes for the framed record byte ring.
// No dependencies; used by the top level, the front end and the back end.
package frb_pkg;

    localparam int LEN_W  = 9;   // record length and offset width
    localparam int DROP_W = 32;  // drop counter width

    // action field codes
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NONE    = 3'd1;
    localparam logic [2:0] ST_RESYNC  = 3'd2;
    localparam logic [2:0] ST_DROPPED = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_IGNORE = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_cmd;

    typedef struct packed {
        logic [DROP_W-1:0] dropped_count;
        logic [2:0]        status;
        logic              read_last;
        logic              read_valid;
        logic [7:0]        read_byte;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_RD_LEN  = 3'b010,
        S_RD_BYTE = 3'b100
    } t_back_state;

endpackage

### hdl/framed_record_byte_ring.sv
// Items wait in the front queue; the back end takes one when idle and registers its
// result. Push, clear, ignored items and a pop on too few bytes answer on take; a pop
// answers a bad or short length byte from S_RD_LEN, reads an open record's byte in
// S_RD_BYTE, opens a record via S_RD_LEN then S_RD_BYTE. One item a cycle for
// push/clear while results are taken; a pop holds the back end. One item at a time.
// Reset: synchronous, active low; pointers, counters and enable clear at once,
// ring contents stay undefined (no clearing pass, only committed bytes are read).
module framed_record_byte_ring #(
    parameter int RING_BYTES    = 4096,
    parameter int REC_MAX_BYTES = 264,
    parameter int REC_OVERHEAD  = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration: ring_enable
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // last_byte
    input  logic [1:0]   s_axis_tuser,   // [1:0] action
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // [7:0] read_byte, [39:8] dropped_count
    output logic         m_axis_tlast,   // read_last
    output logic [3:0]   m_axis_tuser    // [0] read_valid, [3:1] status
);

    localparam int AW = $clog2(RING_BYTES);
    localparam logic [AW:0] RING_SZ = (AW+1)'(RING_BYTES);

    // enable register; the user must write it only while the block is idle (unenforced)
    logic r_ring_enable;

    frb_pkg::t_cmd    w_cmd;
    logic             w_cmd_valid, w_cmd_ready;
    frb_pkg::t_result w_res;
    logic             w_wr_en, w_rd_en;
    logic [AW-1:0]    w_wr_addr, w_rd_addr;
    logic [7:0]       w_wr_data, w_rd_data;
    logic [AW:0]      w_used;
    logic             w_ign_take, w_res_ign;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_enable <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ring_enable <= i_cfg_data;
        end
    end

    // front: classify and queue (two entries)
    frb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_enable      (r_ring_enable),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready),
        .o_cmd         (w_cmd)
    );

    // back: ring pointers, record framing, result register
    frb_back #(
        .RING_BYTES    (RING_BYTES),
        .REC_MAX_BYTES (REC_MAX_BYTES),
        .REC_OVERHEAD  (REC_OVERHEAD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res),
        .o_used      (w_used)
    );

    // byte ring storage
    frb_ram #(
        .WIDTH (8),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign m_axis_tdata = {w_res.dropped_count, w_res.read_byte};
    assign m_axis_tuser = {w_res.status, w_res.read_valid};
    assign m_axis_tlast = w_res.read_last;

    // back end taking an ignored command, and an ignored answer on the output
    assign w_ign_take = w_cmd_valid && w_cmd_ready && (w_cmd.op == frb_pkg::OP_IGNORE);
    assign w_res_ign  = m_axis_tvalid && (w_res.status == frb_pkg::ST_IGNORED);

    `include "framed_record_byte_ring_assert.svh"

    // head never runs more than a ring ahead of tail
    `FRB_ASSERT_IMPLIES(a_used_bound, 1'b1, w_used <= RING_SZ, "ring occupancy exceeds size")
    // back end never writes and reads the ring in one cycle
    `FRB_ASSERT_IMPLIES(a_ram_excl, w_wr_en, !w_rd_en, "ring write and read collide")
    // a record end is always a popped byte
    `FRB_ASSERT_IMPLIES(a_last_valid, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0], "tlast alone")
    // an ignored command answers in the next cycle
    `FRB_ASSERT_NEXT(a_ignore_resp, w_ign_take, w_res_ign, "ignored item lost")

endmodule

### hdl/frb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/frb_front.sv
// Front end: accepts items, classifies the action and queues commands.
// Depends on frb_pkg.
module frb_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_enable,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic [1:0]   s_axis_tuser,
    output logic         o_cmd_valid,
    input  logic         i_cmd_ready,
    output frb_pkg::t_cmd o_cmd
);

    localparam int Q_DEPTH = 2;
    localparam int QI_W    = $clog2(Q_DEPTH);

    frb_pkg::t_cmd  r_q [Q_DEPTH];
    logic [QI_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QI_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QI_W:0]   r_count,  n_count;
    frb_pkg::t_cmd  w_new;
    logic           w_push, w_pop;

    // classify: disabled pushes and the unused code become ignore
    always_comb begin
        w_new.data_byte = s_axis_tdata;
        w_new.last_byte = s_axis_tlast;
        unique case (s_axis_tuser)
            frb_pkg::ACT_PUSH:  w_new.op = i_enable ? frb_pkg::OP_PUSH : frb_pkg::OP_IGNORE;
            frb_pkg::ACT_POP:   w_new.op = frb_pkg::OP_POP;
            frb_pkg::ACT_CLEAR: w_new.op = frb_pkg::OP_CLEAR;
            default:            w_new.op = frb_pkg::OP_IGNORE;
        endcase
    end

    assign s_axis_tready = (r_count != (QI_W+1)'(Q_DEPTH));
    assign o_cmd_valid   = (r_count != '0);
    assign o_cmd         = r_q[r_rd_ptr];
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign w_pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (QI_W+1)'(w_push) - (QI_W+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_new;
        end
    end

endmodule

### hdl/frb_back.sv
// Back end: runs queued commands against the ring memory and registers results.
// Depends on frb_pkg; drives the ports of an frb_ram instance.
module frb_back #(
    parameter int RING_BYTES    = 4096,
    parameter int REC_MAX_BYTES = 264,
    parameter int REC_OVERHEAD  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  frb_pkg::t_cmd                 i_cmd,
    output logic                          o_wr_en,
    output logic [$clog2(RING_BYTES)-1:0] o_wr_addr,
    output logic [7:0]                    o_wr_data,
    output logic                          o_rd_en,
    output logic [$clog2(RING_BYTES)-1:0] o_rd_addr,
    input  logic [7:0]                    i_rd_data,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output frb_pkg::t_result              o_res,
    output logic [$clog2(RING_BYTES):0]   o_used
);

    localparam int AW = $clog2(RING_BYTES);
    localparam int PW = AW + 1;
    localparam int LW = frb_pkg::LEN_W;
    localparam int DW = frb_pkg::DROP_W;
    localparam int CW = (PW > LW) ? PW + 1 : LW + 2;   // common compare width

    localparam logic [PW-1:0] RING_SZ = PW'(RING_BYTES);
    localparam logic [CW-1:0] MAX_C   = CW'(REC_MAX_BYTES);
    localparam logic [CW-1:0] OVH_C   = CW'(REC_OVERHEAD);
    localparam logic [LW-1:0] OVH_L   = LW'(REC_OVERHEAD);

    frb_pkg::t_back_state r_state, n_state;
    logic [PW-1:0] r_head, n_head, r_tail, n_tail;
    logic [LW-1:0] r_push_len, n_push_len;
    logic          r_push_ov, n_push_ov;
    logic [LW-1:0] r_pop_off, n_pop_off, r_pop_total, n_pop_total;
    logic [DW-1:0] r_drop, n_drop;
    logic          r_out_valid, n_out_valid;
    frb_pkg::t_result r_out, w_res;
    logic          w_emit;

    logic [PW-1:0] w_used, w_room;
    logic          w_out_free, w_take;
    logic [LW:0]   w_len_inc;
    logic          w_grow, w_store, w_over;
    logic [LW-1:0] w_len_n;
    logic [DW:0]   w_drop_sum;
    logic [DW-1:0] w_drop_sat;
    logic [PW-1:0] w_wr_ptr;
    logic [LW-1:0] w_total, w_off_inc;
    logic [PW-1:0] w_rd_ptr;

    assign w_used     = r_head - r_tail;
    assign w_room     = RING_SZ - w_used;
    assign w_out_free = !r_out_valid || i_res_ready;
    assign o_cmd_ready = (r_state == frb_pkg::S_IDLE) && w_out_free;
    assign w_take     = i_cmd_valid && o_cmd_ready;

    // push bookkeeping
    assign w_len_inc  = {1'b0, r_push_len} + 1'b1;
    assign w_grow     = !r_push_ov && (CW'(w_len_inc) <= MAX_C);
    assign w_len_n    = w_grow ? w_len_inc[LW-1:0] : r_push_len;
    assign w_store    = w_grow && (CW'(r_push_len) < CW'(w_room));
    assign w_over     = CW'(w_len_n) > CW'(w_room);
    assign w_drop_sum = {1'b0, r_drop} + (DW+1)'(w_len_n);
    assign w_drop_sat = w_drop_sum[DW] ? '1 : w_drop_sum[DW-1:0];
    assign w_wr_ptr   = r_head + PW'(r_push_len);

    // pop bookkeeping
    assign w_total    = OVH_L + LW'(i_rd_data);
    assign w_off_inc  = r_pop_off + 1'b1;

    assign o_wr_en   = w_take && (i_cmd.op == frb_pkg::OP_PUSH) && w_store;
    assign o_wr_addr = w_wr_ptr[AW-1:0];
    assign o_wr_data = i_cmd.data_byte;
    assign o_rd_addr = w_rd_ptr[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_push_len  = r_push_len;
        n_push_ov   = r_push_ov;
        n_pop_off   = r_pop_off;
        n_pop_total = r_pop_total;
        n_drop      = r_drop;
        o_rd_en     = 1'b0;
        w_rd_ptr    = r_tail + PW'(r_pop_off);
        w_emit      = 1'b0;
        w_res       = '0;

        unique case (r_state)
            frb_pkg::S_IDLE: begin
                if (w_take) begin
                    unique case (i_cmd.op)
                        frb_pkg::OP_PUSH: begin
                            w_emit = 1'b1;
                            if (!i_cmd.last_byte) begin
                                n_push_len   = w_len_n;
                                n_push_ov    = !w_grow;
                                w_res.status = w_grow ? frb_pkg::ST_OK : frb_pkg::ST_IGNORED;
                            end else begin
                                n_push_len = '0;
                                n_push_ov  = 1'b0;
                                priority if (!w_grow) begin
                                    w_res.status = frb_pkg::ST_IGNORED;
                                end else if (w_over) begin
                                    n_drop       = w_drop_sat;
                                    w_res.status = frb_pkg::ST_DROPPED;
                                end else begin
                                    n_head       = r_head + PW'(w_len_n);
                                    w_res.status = frb_pkg::ST_OK;
                                end
                            end
                        end
                        frb_pkg::OP_POP: begin
                            priority if (r_pop_total != '0) begin
                                o_rd_en = 1'b1;
                                n_state = frb_pkg::S_RD_BYTE;
                            end else if (CW'(w_used) < OVH_C) begin
                                w_emit       = 1'b1;
                                w_res.status = frb_pkg::ST_NONE;
                            end else begin
                                // fetch the length byte at offset 1
                                o_rd_en  = 1'b1;
                                w_rd_ptr = r_tail + 1'b1;
                                n_state  = frb_pkg::S_RD_LEN;
                            end
                        end
                        frb_pkg::OP_CLEAR: begin
                            w_emit              = 1'b1;
                            w_res.dropped_count = r_drop;
                            w_res.status        = frb_pkg::ST_OK;
                            n_drop              = '0;
                        end
                        default: begin
                            w_emit       = 1'b1;
                            w_res.status = frb_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            frb_pkg::S_RD_LEN: begin
                priority if (CW'(w_total) > MAX_C) begin
                    if (w_out_free) begin
                        w_emit       = 1'b1;
                        w_res.status = frb_pkg::ST_RESYNC;
                        n_tail       = r_head;
                        n_state      = frb_pkg::S_IDLE;
                    end
                end else if (CW'(w_used) < CW'(w_total)) begin
                    if (w_out_free) begin
                        w_emit       = 1'b1;
                        w_res.status = frb_pkg::ST_NONE;
                        n_state      = frb_pkg::S_IDLE;
                    end
                end else begin
                    // record complete: open it and fetch its first byte
                    n_pop_total = w_total;
                    n_pop_off   = '0;
                    o_rd_en     = 1'b1;
                    w_rd_ptr    = r_tail;
                    n_state     = frb_pkg::S_RD_BYTE;
                end
            end
            frb_pkg::S_RD_BYTE: begin
                if (w_out_free) begin
                    w_emit           = 1'b1;
                    w_res.read_byte  = i_rd_data;
                    w_res.read_valid = 1'b1;
                    w_res.status     = frb_pkg::ST_OK;
                    n_state          = frb_pkg::S_IDLE;
                    if (w_off_inc >= r_pop_total) begin
                        w_res.read_last = 1'b1;
                        n_tail          = r_tail + PW'(r_pop_total);
                        n_pop_total     = '0;
                        n_pop_off       = '0;
                    end else begin
                        n_pop_off = w_off_inc;
                    end
                end
            end
            default: n_state = frb_pkg::S_IDLE;
        endcase

        n_out_valid = w_emit ? 1'b1 : (i_res_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frb_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_push_len  <= '0;
            r_push_ov   <= 1'b0;
            r_pop_off   <= '0;
            r_pop_total <= '0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_push_len  <= n_push_len;
            r_push_ov   <= n_push_ov;
            r_pop_off   <= n_pop_off;
            r_pop_total <= n_pop_total;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_used      = w_used;

endmodule
